// ----- sv/tlbpt_pkg.sv -----
// Shared constants, types and state encoding for the TLB / page table translator.
package tlbpt_pkg;

	// Sizing of the translation structures
	localparam int TLB_ENTRIES = 16;
	localparam int PAGE_COUNT  = 256;
	localparam int FRAME_BYTES = 256;

	// Field widths
	localparam int ADDR_W     = 16;
	localparam int PAGE_W     = 8;
	localparam int OFFSET_W   = 8;
	localparam int FRAME_W    = 8;
	localparam int FREE_CTR_W = 9;
	localparam int COUNT_W    = 32;

	// Derived widths
	localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
	localparam int PT_IDX_W    = $clog2(PAGE_COUNT);
	localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
	localparam int PHYS_EXT_W  = ADDR_W + FRAME_SHIFT;

	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [PAGE_W-1:0]     page_t;
	typedef logic [OFFSET_W-1:0]   offset_t;
	typedef logic [FRAME_W-1:0]    frame_t;
	typedef logic [TLB_IDX_W-1:0]  tlb_idx_t;
	typedef logic [PT_IDX_W-1:0]   pt_idx_t;
	typedef logic [FREE_CTR_W-1:0] free_ctr_t;
	typedef logic [COUNT_W-1:0]    count_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} tlbpt_state_t;

endpackage

// ----- sv/tlbpt_req_if.sv -----
// Request channel: one logical address per transaction.
interface tlbpt_req_if;
	import tlbpt_pkg::*;

	logic  valid;
	logic  ready;
	addr_t logical_address;

	modport source (output valid, output logical_address, input ready);
	modport sink   (input valid, input logical_address, output ready);

endinterface

// ----- sv/tlbpt_rsp_if.sv -----
// Response channel: translated address, flags and running counts per transaction.
interface tlbpt_rsp_if;
	import tlbpt_pkg::*;

	logic   valid;
	logic   ready;
	addr_t  physical_address;
	logic   tlb_hit;
	logic   page_fault;
	count_t hit_count;
	count_t fault_count;

	modport source (
		output valid, output physical_address, output tlb_hit, output page_fault,
		output hit_count, output fault_count, input ready
	);
	modport sink (
		input valid, input physical_address, input tlb_hit, input page_fault,
		input hit_count, input fault_count, output ready
	);

endinterface

// ----- sv/tlb_page_table_translate_core.sv -----
// A request is taken in ST_IDLE; in ST_SCAN the single tag comparator steps through one TLB entry per
// cycle while the page table read overlaps that scan, and ST_UPDATE commits the result into the
// response register. No new request is taken until that commit.
// The response register holds a finished result while the next request is taken.
// Reset: TLB valid bits, page mapped bits, FIFO pointer, free frame counter and both
// counts clear at once; page table contents are undefined until a page is mapped.
module tlb_page_table_translate_core (
	input  logic        clk,
	input  logic        arst_n,
	tlbpt_req_if.sink   req,
	tlbpt_rsp_if.source rsp
);
	import tlbpt_pkg::*;

	// TLB storage
	page_t  tlb_tag_q   [TLB_ENTRIES];
	frame_t tlb_frame_q [TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0] tlb_valid_q;
	tlb_idx_t repl_ptr_q;

	// Page table storage
	frame_t pt_mem [PAGE_COUNT];
	frame_t pt_rdata_q;
	logic [PAGE_COUNT-1:0] page_mapped_q;
	free_ctr_t next_free_q;

	// Per-transaction working registers
	tlbpt_state_t state_q, state_d;
	page_t    page_q;
	offset_t  offset_q;
	pt_idx_t  pidx_q;
	tlb_idx_t scan_idx_q;
	logic     hit_q;
	frame_t   hit_frame_q;

	// Running counts
	count_t hit_total_q;
	count_t fault_total_q;

	// Response register
	logic   out_valid_q;
	addr_t  out_phys_q;
	logic   out_hit_q;
	logic   out_fault_q;
	count_t out_hits_q;
	count_t out_faults_q;

	// Sequencer controls
	logic in_ready;
	logic scan_en;
	logic scan_last;
	logic commit;

	// Commit datapath
	logic   tag_match;
	logic   fault;
	frame_t frame_sel;
	logic [PHYS_EXT_W-1:0] frame_ext;
	addr_t  phys_addr;

	// Shared tag comparator, one TLB entry per cycle
	assign tag_match = tlb_valid_q[scan_idx_q] && (tlb_tag_q[scan_idx_q] == page_q);
	assign scan_last = (scan_idx_q == TLB_IDX_W'(TLB_ENTRIES - 1));

	// Resolve the frame at commit
	assign fault     = !hit_q && !page_mapped_q[pidx_q];
	assign frame_sel = hit_q ? hit_frame_q :
		(page_mapped_q[pidx_q] ? pt_rdata_q : next_free_q[FRAME_W-1:0]);
	assign frame_ext = PHYS_EXT_W'(frame_sel);
	assign phys_addr = ADDR_W'(frame_ext << FRAME_SHIFT) + ADDR_W'(offset_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (!out_valid_q || rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		scan_en  = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_SCAN:   scan_en  = 1'b1;
			ST_UPDATE: commit   = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	assign req.ready = in_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the request and walk the TLB
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			hit_q      <= 1'b0;
		end else if (req.valid && in_ready) begin
			scan_idx_q <= '0;
			hit_q      <= 1'b0;
		end else if (scan_en) begin
			scan_idx_q <= scan_last ? '0 : scan_idx_q + 1'b1;
			if (tag_match) hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && in_ready) begin
			page_q   <= req.logical_address[ADDR_W-1:OFFSET_W];
			offset_q <= req.logical_address[OFFSET_W-1:0];
			pidx_q   <= PT_IDX_W'(req.logical_address[ADDR_W-1:OFFSET_W]);
		end
		// Last match wins
		if (scan_en && tag_match) hit_frame_q <= tlb_frame_q[scan_idx_q];
	end

	// Page table memory: read every cycle, write on a fault
	always_ff @(posedge clk) begin
		pt_rdata_q <= pt_mem[pidx_q];
		if (commit && fault) pt_mem[pidx_q] <= next_free_q[FRAME_W-1:0];
	end

	// Mapped bits, free frame counter, FIFO pointer and TLB valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_mapped_q <= '0;
			next_free_q   <= '0;
			repl_ptr_q    <= '0;
			tlb_valid_q   <= '0;
		end else if (commit && !hit_q) begin
			tlb_valid_q[repl_ptr_q] <= 1'b1;
			repl_ptr_q <= (repl_ptr_q == TLB_IDX_W'(TLB_ENTRIES - 1)) ? '0 : repl_ptr_q + 1'b1;
			if (fault) begin
				page_mapped_q[pidx_q] <= 1'b1;
				next_free_q <= next_free_q + 1'b1;
			end
		end
	end

	// Fill the TLB slot on a miss
	always_ff @(posedge clk) begin
		if (commit && !hit_q) begin
			tlb_tag_q[repl_ptr_q]   <= page_q;
			tlb_frame_q[repl_ptr_q] <= frame_sel;
		end
	end

	// Saturating hit and fault counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_total_q   <= '0;
			fault_total_q <= '0;
		end else if (commit) begin
			if (hit_q && (hit_total_q != '1)) hit_total_q <= hit_total_q + 1'b1;
			if (fault && (fault_total_q != '1)) fault_total_q <= fault_total_q + 1'b1;
		end
	end

	// Response register: load on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_phys_q   <= phys_addr;
			out_hit_q    <= hit_q;
			out_fault_q  <= fault;
			out_hits_q   <= (hit_q && (hit_total_q != '1)) ? hit_total_q + 1'b1 : hit_total_q;
			out_faults_q <= (fault && (fault_total_q != '1)) ? fault_total_q + 1'b1
				: fault_total_q;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.physical_address = out_phys_q;
	assign rsp.tlb_hit          = out_hit_q;
	assign rsp.page_fault       = out_fault_q;
	assign rsp.hit_count        = out_hits_q;
	assign rsp.fault_count      = out_faults_q;

	// A transaction never reports both a TLB hit and a page fault
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_hit_q && out_fault_q))
	else $error("hit and fault reported together");

	// A miss leaves its page mapped
	assert property (@(posedge clk) disable iff (!arst_n)
		(commit && !hit_q) |=> page_mapped_q[$past(pidx_q)])
	else $error("page not mapped after miss");

	// The FIFO pointer moves only on a miss commit
	assert property (@(posedge clk) disable iff (!arst_n)
		(repl_ptr_q != $past(repl_ptr_q)) |-> $past(commit && !hit_q))
	else $error("replacement pointer moved without a miss");

	// The fault count moves only on a fault commit
	assert property (@(posedge clk) disable iff (!arst_n)
		(fault_total_q != $past(fault_total_q)) |-> $past(commit && fault))
	else $error("fault count moved without a fault");

endmodule
